FILE: src/websocket_frame_deframer_core_defines.svh
// ----------------------------------------------------------------------------
// WebSocket deframer assertion macros
// Shared property wrappers for the deframer modules, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication.
`define WSDF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define WSDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/wsdf_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Types, opcodes and result codes shared by the deframer modules.
// ----------------------------------------------------------------------------
package wsdf_pkg;

    localparam int LEN_W = 17;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 17'h10000;

    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT16,
        PH_EXT64,
        PH_MASK,
        PH_DATA
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_EMPTY,
        KIND_CLOSE,
        KIND_OVERSIZE
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  opcode;
        logic [7:0]  data;
        logic        last;
    } t_result;

endpackage

FILE: src/websocket_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer core
// Parses received WebSocket frames one byte per item, unmasks the payload
// and emits text and ping payload bytes and empty, close and oversize results.
// ----------------------------------------------------------------------------
// The block takes one byte per clock and can sustain one item every cycle on
// both sides unless the output stalls; each byte passes an input register, the
// header state machine and a result register. Header, mask key and dropped
// payload bytes give no item unless they end a header or a close frame. After
// a close frame completes or a frame exceeds max_payload the block swallows
// every byte until reset. The user must write max_payload through the
// configuration channel only while the stream is idle; it is not enforced.

module websocket_frame_deframer_core
    import wsdf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [LEN_W-1:0] i_cfg_data,     // max_payload
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [7:0]       i_s_tdata,      // [7:0] rx_byte
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [15:0]      o_m_tdata,      // [3:0] frame_opcode, [11:4] data, zero pad
    output logic [1:0]       o_m_tuser,      // [1:0] kind
    output logic             o_m_tlast
);

    logic [LEN_W-1:0] r_max_payload;
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    t_result          r_out;

    logic             w_advance;
    logic             w_step;
    logic             w_res_valid;
    t_result          w_res;

    assign o_cfg_ready = 1'b1;

    // The result register moves whenever it is empty or being drained, and
    // the input register feeds the parser in the same cycle.
    assign w_advance  = !r_out_valid || i_m_tready;
    assign w_step     = r_in_valid && w_advance;
    assign o_s_tready = !r_in_valid || w_advance;

    wsdf_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_byte        (r_in_byte),
        .i_max_payload (r_max_payload),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_payload <= i_cfg_data;
            end
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= w_step && w_res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
        if (w_step && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out.data, r_out.opcode};
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.last;

endmodule

FILE: src/wsdf_parser.sv
// ----------------------------------------------------------------------------
// WebSocket frame parser
// Header state machine, length check and payload unmasking for one byte
// per step, with the result produced combinationally from the current byte.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_core_defines.svh"

module wsdf_parser
    import wsdf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic [LEN_W-1:0] i_max_payload,
    output logic             o_res_valid,
    output t_result          o_res
);

    localparam logic [2:0] EXT16_END = 3'd1;
    localparam logic [2:0] EXT64_END = 3'd7;
    localparam logic [2:0] MASK_END  = 3'd3;

    t_phase           r_phase,     n_phase;
    logic [3:0]       r_opcode,    n_opcode;
    logic             r_masked,    n_masked;
    logic [LEN_W-1:0] r_len,       n_len;
    logic             r_len_over,  n_len_over;
    logic [2:0]       r_cnt,       n_cnt;
    logic [31:0]      r_mask_key,  n_mask_key;
    logic [LEN_W-1:0] r_remaining, n_remaining;
    logic [1:0]       r_key_idx,   n_key_idx;
    logic             r_halted,    n_halted;

    logic [6:0]       w_len7;
    logic             w_len7_ext;
    logic [LEN_W-1:0] w_ext_lo;
    logic             w_ext_over;
    logic             w_ext_end;
    logic [LEN_W-1:0] w_cand_lo;
    logic             w_cand_over;
    logic             w_len_done;
    logic             w_oversize;
    logic             w_masked_now;
    logic             w_start;
    logic [LEN_W-1:0] w_start_len;
    logic             w_start_zero;
    logic [LEN_W-1:0] w_rem_dec;
    logic             w_data_last;
    logic             w_emitted;
    logic             w_is_close;
    logic [7:0]       w_key_byte;
    logic             w_halt_now;

    assign w_len7     = i_byte[6:0];
    assign w_len7_ext = (w_len7 == LEN7_EXT16) || (w_len7 == LEN7_EXT64);

    // Only the low 17 bits of a long length are kept; anything shifted out
    // of that window marks the length as too large for any limit.
    assign w_ext_lo   = {r_len[LEN_W-9:0], i_byte};
    assign w_ext_over = r_len_over | (|r_len[LEN_W-1:LEN_W-8]);
    assign w_ext_end  = ((r_phase == PH_EXT16) && (r_cnt == EXT16_END)) ||
                        ((r_phase == PH_EXT64) && (r_cnt == EXT64_END));

    assign w_cand_lo   = (r_phase == PH_HDR1) ? {{(LEN_W-7){1'b0}}, w_len7} : w_ext_lo;
    assign w_cand_over = (r_phase == PH_HDR1) ? 1'b0 : w_ext_over;
    assign w_len_done  = ((r_phase == PH_HDR1) && !w_len7_ext) || w_ext_end;
    assign w_oversize  = w_cand_over || (w_cand_lo > i_max_payload);

    assign w_masked_now = (r_phase == PH_HDR1) ? i_byte[7] : r_masked;
    assign w_start      = (w_len_done && !w_oversize && !w_masked_now) ||
                          ((r_phase == PH_MASK) && (r_cnt == MASK_END));
    assign w_start_len  = (r_phase == PH_MASK) ? r_len : w_cand_lo;
    assign w_start_zero = (w_start_len == '0);

    assign w_rem_dec   = r_remaining - {{(LEN_W-1){1'b0}}, 1'b1};
    assign w_data_last = (w_rem_dec == '0);
    assign w_emitted   = (r_opcode == OP_TEXT) || (r_opcode == OP_PING);
    assign w_is_close  = (r_opcode == OP_CLOSE);

    always_comb begin
        case (r_key_idx)
            2'd0:    w_key_byte = r_mask_key[31:24];
            2'd1:    w_key_byte = r_mask_key[23:16];
            2'd2:    w_key_byte = r_mask_key[15:8];
            default: w_key_byte = r_mask_key[7:0];
        endcase
    end

    assign w_halt_now = (w_len_done && w_oversize) ||
                        (w_start && w_start_zero && w_is_close) ||
                        ((r_phase == PH_DATA) && w_data_last && !w_emitted && w_is_close);

    // Next state.
    always_comb begin
        n_phase     = r_phase;
        n_opcode    = r_opcode;
        n_masked    = r_masked;
        n_len       = r_len;
        n_len_over  = r_len_over;
        n_cnt       = r_cnt;
        n_mask_key  = r_mask_key;
        n_remaining = r_remaining;
        n_key_idx   = r_key_idx;
        n_halted    = r_halted;
        if (i_step && !r_halted) begin
            case (r_phase)
                PH_HDR0: begin
                    n_opcode = i_byte[3:0];
                    n_phase  = PH_HDR1;
                end
                PH_HDR1: begin
                    n_masked   = i_byte[7];
                    n_cnt      = '0;
                    n_len_over = 1'b0;
                    n_len      = w_len7_ext ? '0 : w_cand_lo;
                    if (w_len7 == LEN7_EXT16) begin
                        n_phase = PH_EXT16;
                    end else if (w_len7 == LEN7_EXT64) begin
                        n_phase = PH_EXT64;
                    end
                end
                PH_EXT16, PH_EXT64: begin
                    n_len      = w_ext_lo;
                    n_len_over = w_ext_over;
                    if (!w_ext_end) begin
                        n_cnt = r_cnt + 3'd1;
                    end
                end
                PH_MASK: begin
                    n_mask_key = {r_mask_key[23:0], i_byte};
                    if (r_cnt != MASK_END) begin
                        n_cnt = r_cnt + 3'd1;
                    end
                end
                PH_DATA: begin
                    n_key_idx   = r_key_idx + 2'd1;
                    n_remaining = w_rem_dec;
                    if (w_data_last) begin
                        n_phase = PH_HDR0;
                    end
                end
                default: begin
                    n_phase = PH_HDR0;
                end
            endcase

            // A finished length either stops the stream, moves on to the
            // mask key, starts the payload, or ends an empty frame.
            if (w_len_done && !w_oversize && w_masked_now) begin
                n_cnt   = '0;
                n_phase = PH_MASK;
            end
            if (w_start) begin
                if (w_start_zero) begin
                    n_phase = PH_HDR0;
                end else begin
                    n_remaining = w_start_len;
                    n_key_idx   = '0;
                    n_phase     = PH_DATA;
                end
            end
            if (w_halt_now) begin
                n_halted = 1'b1;
            end
        end
    end

    // Result for the current byte.
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '{kind: KIND_BYTE, opcode: r_opcode, data: 8'd0, last: 1'b0};
        if (!r_halted) begin
            if (w_len_done && w_oversize) begin
                o_res_valid = 1'b1;
                o_res.kind  = KIND_OVERSIZE;
            end else if (w_start && w_start_zero) begin
                if (w_is_close) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_CLOSE;
                end else if (w_emitted) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_EMPTY;
                    o_res.last  = 1'b1;
                end
            end else if (r_phase == PH_DATA) begin
                if (w_emitted) begin
                    o_res_valid = 1'b1;
                    o_res.data  = r_masked ? (i_byte ^ w_key_byte) : i_byte;
                    o_res.last  = w_data_last;
                end else if (w_is_close && w_data_last) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_CLOSE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR0;
            r_opcode    <= '0;
            r_masked    <= 1'b0;
            r_len       <= '0;
            r_len_over  <= 1'b0;
            r_cnt       <= '0;
            r_mask_key  <= '0;
            r_remaining <= '0;
            r_key_idx   <= '0;
            r_halted    <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_opcode    <= n_opcode;
            r_masked    <= n_masked;
            r_len       <= n_len;
            r_len_over  <= n_len_over;
            r_cnt       <= n_cnt;
            r_mask_key  <= n_mask_key;
            r_remaining <= n_remaining;
            r_key_idx   <= n_key_idx;
            r_halted    <= n_halted;
        end
    end

    `WSDF_ASSERT_NEXT(a_halt_sticky, r_halted, r_halted, "halt flag cleared without reset")
    `WSDF_ASSERT_SAME(a_halt_silent, r_halted, !o_res_valid, "result produced after halt")
    `WSDF_ASSERT_SAME(a_close_opcode, o_res_valid && (o_res.kind == KIND_CLOSE),
        o_res.opcode == OP_CLOSE, "close result without close opcode")
    `WSDF_ASSERT_SAME(a_byte_opcode,
        o_res_valid && ((o_res.kind == KIND_BYTE) || (o_res.kind == KIND_EMPTY)),
        (o_res.opcode == OP_TEXT) || (o_res.opcode == OP_PING),
        "payload result for a dropped opcode")

endmodule

FILE: bench/tb_websocket_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer core testbench
// Feeds framed byte streams (short, 16-bit and 64-bit lengths, masked and
// unmasked, delivered and dropped opcodes) and compares every output item
// against a cycle-free model of the parser. max_payload is changed between
// traffic phases, and the run ends with a close or an oversize frame that
// stops the parser.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer_core;
    import wsdf_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_SHOWN = 10;

    typedef enum {LEN_SHORT, LEN_EXT16, LEN_EXT64} t_len_form;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = 8'h00;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [15:0]      m_tdata;
    logic [1:0]       m_tuser;
    logic             m_tlast;

    websocket_frame_deframer_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast)
    );

    always #6 clk = ~clk;

    // Parser state mirrored from the block.
    logic [LEN_W-1:0] p_max_payload = MAX_PAYLOAD_RST;
    t_phase           p_phase = PH_HDR0;
    logic [3:0]       p_opcode = 4'h0;
    logic             p_masked = 1'b0;
    logic [63:0]      p_len = 64'd0;
    logic [2:0]       p_cnt = 3'd0;
    logic [31:0]      p_key = 32'd0;
    logic [LEN_W-1:0] p_remain = '0;
    logic [1:0]       p_key_idx = 2'd0;
    logic             p_halted = 1'b0;
    t_result          p_out;

    logic [7:0]  tx_bytes[$];
    t_result     predicted_results[$];
    int unsigned bytes_queued = 0;
    int unsigned bytes_taken = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    function automatic bit emit(t_kind kind, logic [3:0] opcode, logic [7:0] data, logic last);
        p_out = '{kind: kind, opcode: opcode, data: data, last: last};
        return 1'b1;
    endfunction

    function automatic bit is_delivered(logic [3:0] opcode);
        return opcode == OP_TEXT || opcode == OP_PING;
    endfunction

    // Header and mask key are done: either finish an empty frame or start the body.
    function automatic bit open_payload();
        if (p_len == 64'd0) begin
            p_phase = PH_HDR0;
            if (p_opcode == OP_CLOSE) begin
                p_halted = 1'b1;
                return emit(KIND_CLOSE, OP_CLOSE, 8'h00, 1'b0);
            end
            if (is_delivered(p_opcode))
                return emit(KIND_EMPTY, p_opcode, 8'h00, 1'b1);
            return 1'b0;
        end
        p_remain = p_len[LEN_W-1:0];
        p_key_idx = 2'd0;
        p_phase = PH_DATA;
        return 1'b0;
    endfunction

    // The length check happens before any mask key byte is read.
    function automatic bit close_length();
        if (p_len > {{(64-LEN_W){1'b0}}, p_max_payload}) begin
            p_halted = 1'b1;
            return emit(KIND_OVERSIZE, p_opcode, 8'h00, 1'b0);
        end
        if (p_masked) begin
            p_cnt = 3'd0;
            p_key = 32'd0;
            p_phase = PH_MASK;
            return 1'b0;
        end
        return open_payload();
    endfunction

    function automatic bit deframe_byte(logic [7:0] rx);
        logic [7:0] b;
        b = rx;
        if (p_halted)
            return 1'b0;
        case (p_phase)
            PH_HDR0: begin
                p_opcode = b[3:0];
                p_phase = PH_HDR1;
                return 1'b0;
            end
            PH_HDR1: begin
                p_masked = b[7];
                p_len = 64'd0;
                p_cnt = 3'd0;
                if (b[6:0] == LEN7_EXT16) begin
                    p_phase = PH_EXT16;
                    return 1'b0;
                end
                if (b[6:0] == LEN7_EXT64) begin
                    p_phase = PH_EXT64;
                    return 1'b0;
                end
                p_len = {57'd0, b[6:0]};
                return close_length();
            end
            PH_EXT16, PH_EXT64: begin
                p_len = {p_len[55:0], b};
                if (p_cnt == ((p_phase == PH_EXT16) ? 3'd1 : 3'd7))
                    return close_length();
                p_cnt = p_cnt + 3'd1;
                return 1'b0;
            end
            PH_MASK: begin
                p_key = {p_key[23:0], b};
                if (p_cnt == 3'd3)
                    return open_payload();
                p_cnt = p_cnt + 3'd1;
                return 1'b0;
            end
            PH_DATA: begin
                if (p_masked)
                    b = b ^ p_key[8*(3 - p_key_idx) +: 8];
                p_key_idx = p_key_idx + 2'd1;
                p_remain = p_remain - 1'b1;
                if (p_remain == '0)
                    p_phase = PH_HDR0;
                if (is_delivered(p_opcode))
                    return emit(KIND_BYTE, p_opcode, b, p_remain == '0);
                if (p_opcode == OP_CLOSE && p_remain == '0) begin
                    p_halted = 1'b1;
                    return emit(KIND_CLOSE, OP_CLOSE, 8'h00, 1'b0);
                end
                return 1'b0;
            end
            default: begin
                p_phase = PH_HDR0;
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stream construction
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic queue_header(input logic [3:0] opcode, input bit masked,
                                input logic [63:0] len, input t_len_form form);
        logic [3:0]  flags;
        logic [31:0] key;
        flags = 4'($urandom);
        key = $urandom;
        // FIN and RSV bits are random since the parser ignores them.
        push_byte({flags, opcode});
        case (form)
            LEN_SHORT: push_byte({masked, len[6:0]});
            LEN_EXT16: begin
                push_byte({masked, LEN7_EXT16});
                push_byte(len[15:8]);
                push_byte(len[7:0]);
            end
            default: begin
                push_byte({masked, LEN7_EXT64});
                for (int i = 7; i >= 0; i--)
                    push_byte(len[8*i +: 8]);
            end
        endcase
        if (masked)
            for (int i = 3; i >= 0; i--)
                push_byte(key[8*i +: 8]);
    endtask

    task automatic queue_frame(input logic [3:0] opcode, input bit masked,
                               input int unsigned len, input t_len_form form);
        logic [7:0] b;
        queue_header(opcode, masked, 64'(len), form);
        for (int unsigned i = 0; i < len; i++) begin
            b = 8'($urandom);
            push_byte(b);
        end
    endtask

    // Non-minimal length encodings are legal here and are used on purpose.
    function automatic t_len_form pick_form(logic [63:0] len);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (len < 64'd126)
            return (r < 6) ? LEN_SHORT : (r < 8) ? LEN_EXT16 : LEN_EXT64;
        if (len <= 64'd65535)
            return (r < 6) ? LEN_EXT16 : LEN_EXT64;
        return LEN_EXT64;
    endfunction

    // Close frames are kept for the end since they stop the parser for good.
    function automatic logic [3:0] pick_opcode();
        logic [3:0] op;
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return OP_TEXT;
        if (r < 6)
            return OP_PING;
        op = 4'($urandom);
        while (op == OP_CLOSE)
            op = 4'($urandom);
        return op;
    endfunction

    function automatic int unsigned pick_length(logic [LEN_W-1:0] limit);
        int unsigned r;
        int unsigned len;
        r = $urandom_range(0, 19);
        if (r < 12)
            len = $urandom_range(0, 8);
        else if (r < 18)
            len = $urandom_range(9, 140);
        else
            len = $urandom_range(141, 400);
        if (len > limit)
            len = $urandom_range(0, limit);
        return len;
    endfunction

    task automatic queue_random_traffic(input int unsigned budget);
        int unsigned stop_at;
        int unsigned len;
        stop_at = bytes_queued + budget;
        while (bytes_queued < stop_at) begin
            len = pick_length(p_max_payload);
            queue_frame(pick_opcode(), 1'($urandom_range(0, 1)), len, pick_form(64'(len)));
        end
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (bytes_taken != bytes_queued || predicted_results.size() != 0);
        // Some bytes give no output item, so let the pipeline drain as well.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_payload(input logic [LEN_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        p_max_payload = value;
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps.
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                bytes_taken++;
                if (deframe_byte(s_tdata))
                    predicted_results.push_back(p_out);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (tx_bytes.size() != 0) begin
                    s_tdata <= tx_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: checks each output item and drives tready in stall modes.
    // ------------------------------------------------------------------
    int unsigned results_seen = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned stall_mode = 0;
    int unsigned mode_left = 0;
    int unsigned rx_tick = 0;

    always @(posedge clk) begin : receiver
        t_result got;
        t_result want;
        rx_tick++;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                got.kind = t_kind'(m_tuser);
                got.opcode = m_tdata[3:0];
                got.data = m_tdata[11:4];
                got.last = m_tlast;
                if (predicted_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected item: kind %0d op %h data %h last %b",
                                 got.kind, got.opcode, got.data, got.last);
                end else begin
                    want = predicted_results.pop_front();
                    if (got.kind !== want.kind || got.opcode !== want.opcode ||
                        got.data !== want.data || got.last !== want.last ||
                        m_tdata[15:12] !== 4'h0) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display({"item %0d: expected kind %0d op %h data %h last %b,",
                                      " got kind %0d op %h data %h last %b pad %h"},
                                     results_seen, want.kind, want.opcode, want.data,
                                     want.last, got.kind, got.opcode, got.data, got.last,
                                     m_tdata[15:12]);
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && results_seen >= 200) begin
                // One long hold-off so the block backs up into its input.
                hold_done = 1'b1;
                hold_left = 600;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(50, 300);
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (rx_tick % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus phases
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [LEN_W-1:0] limit;
        logic [63:0]      over;
        int unsigned      len;
        logic [7:0]       junk;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames at the reset limit.
        queue_frame(OP_TEXT, 1'b0, 1, LEN_SHORT);
        queue_frame(OP_PING, 1'b1, 5, LEN_SHORT);   // key index wraps
        queue_frame(OP_TEXT, 1'b0, 0, LEN_SHORT);   // empty frame end
        queue_frame(OP_PING, 1'b1, 0, LEN_SHORT);   // empty after mask key
        queue_frame(4'hA, 1'b0, 2, LEN_SHORT);      // pong payload is dropped
        queue_frame(4'h0, 1'b0, 1, LEN_EXT16);
        wait_idle();

        // With a zero limit only empty frames get through, in every encoding.
        write_max_payload('0);
        queue_random_traffic(60);
        wait_idle();

        write_max_payload(17'd1);
        queue_random_traffic(100);
        wait_idle();

        write_max_payload(LEN_W'($urandom_range(126, 400)));
        queue_random_traffic(300);
        // One frame exactly at the limit.
        queue_frame(OP_TEXT, 1'b1, 32'(p_max_payload), LEN_EXT64);
        wait_idle();

        write_max_payload(17'd65535);
        queue_random_traffic(200);
        wait_idle();

        write_max_payload(MAX_PAYLOAD_RST);
        queue_random_traffic(160);
        queue_random_traffic(20);
        wait_idle();

        // The stream ends with a close or an oversize frame, then junk.
        write_max_payload(LEN_W'($urandom_range(0, 65536)));
        limit = p_max_payload;
        case ($urandom_range(0, 2))
            0: begin
                len = (limit < 40) ? $urandom_range(0, limit) : $urandom_range(0, 40);
                queue_frame(OP_CLOSE, 1'($urandom_range(0, 1)), len, pick_form(64'(len)));
            end
            1: begin
                over = 64'(limit) + 64'd1;
                queue_header(pick_opcode(), 1'($urandom_range(0, 1)), over, pick_form(over));
            end
            default: begin
                over = {$urandom, $urandom} | 64'h0000_0001_0000_0000;
                queue_header(pick_opcode(), 1'($urandom_range(0, 1)), over, LEN_EXT64);
            end
        endcase
        for (int i = 0; i < 24; i++) begin
            junk = 8'($urandom);
            push_byte(junk);
        end
        wait_idle();

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
